>>> design/rsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_pkg: shared types and constants of the sprite RLE row decoder
// Holds the dimension limit, parse phases, register indexes and the
// structs that move between the step logic, the result buffer and the top.
// ----------------------------------------------------------------------------
package rsd_pkg;

  localparam int MAX_DIM  = 16384;
  localparam int DIM_W    = $clog2(MAX_DIM) + 1;   // holds MAX_DIM itself
  localparam int COL_W    = 14;                    // column / row output width
  localparam int LEN_W    = 9;
  localparam int SUM_W    = DIM_W + 1;             // position plus run length

  localparam logic [7:0] RAW_CODE_WIDE   = 8'd255;
  localparam logic [2:0] RAW_CODE_PACKED = 3'd7;
  localparam logic [4:0] PACK_LEN_MASK   = 5'd31;  // width must be a multiple of 32

  typedef enum logic [1:0] {
    FMT_RAW    = 2'd0,
    FMT_WIDE   = 2'd1,
    FMT_PACKED = 2'd2,
    FMT_PACK32 = 2'd3
  } fmt_t;

  typedef enum logic [1:0] {
    REG_FORMAT = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_CODE = 2'd0,
    PH_LEN  = 2'd1,
    PH_RAW  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_RUN   = 2'd1,
    ERR_WIDTH = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    K_NONE,   // byte ignored
    K_EMIT,   // run known to fit, emit it
    K_OPEN,   // run or raw sequence that must be checked against the row
    K_HOLD,   // format-1 code byte, wait for its length
    K_BAD     // format-3 width not a multiple of 32
  } kind_t;

  typedef struct packed {
    fmt_t             fmt;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic [DIM_W-1:0] col;
    logic [DIM_W-1:0] row;
    phase_t           phase;
    logic [7:0]       held;
    logic [LEN_W-1:0] raw_rem;
    logic             err;
    logic             done;
  } state_t;

  typedef struct packed {
    logic             valid;
    logic [7:0]       pixel_value;
    logic [LEN_W-1:0] run_length;
    logic [COL_W-1:0] column;
    logic [COL_W-1:0] row_index;
    logic             last_of_row;
    logic             last_of_frame;
    err_t             error_code;
  } result_t;

endpackage

>>> design/rsd_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_step: per-byte decode logic
// Takes the current decoder state and one byte, gives the next state and
// the run result (if any) for that byte. Purely combinational.
// ----------------------------------------------------------------------------
module rsd_step import rsd_pkg::*; (
  input  cfg_t       cfg,
  input  state_t     st,
  input  logic [7:0] code_byte,
  input  logic       frame_start,
  output state_t     st_nxt,
  output result_t    res
);

  state_t           cur;
  logic [DIM_W-1:0] w;
  logic [DIM_W-1:0] h;
  kind_t            kind;
  logic [7:0]       run_val;
  logic [LEN_W-1:0] run_len;
  logic             run_raw;
  logic             in_raw;
  logic [LEN_W-1:0] rem_dec;
  logic [SUM_W-1:0] end_col;
  logic [DIM_W:0]   row_inc;
  logic             fits;
  logic             lr;
  logic             lf;

  // Clamp dimensions: zero acts as one, anything above the limit acts as the limit.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    else r = v;
    return r;
  endfunction

  // Classify the byte.
  always_comb begin
    cur = st;
    if (frame_start) begin
      cur = '{col: '0, row: '0, phase: PH_CODE, held: '0, raw_rem: '0,
              err: 1'b0, done: 1'b0};
    end
    w       = eff_dim(cfg.width);
    h       = eff_dim(cfg.height);
    kind    = K_NONE;
    run_val = code_byte;
    run_len = LEN_W'(1);
    run_raw = 1'b0;
    in_raw  = 1'b0;
    if (cur.err || cur.done) begin
      kind = K_NONE;
    end else if (cfg.fmt == FMT_PACK32 && (w[4:0] & PACK_LEN_MASK) != 5'd0) begin
      kind = K_BAD;
    end else if (cur.phase == PH_RAW) begin
      kind   = K_EMIT;
      in_raw = 1'b1;
    end else if (cur.phase == PH_LEN) begin
      kind    = K_OPEN;
      run_val = cur.held;
      run_len = {1'b0, code_byte} + LEN_W'(1);
      run_raw = (cur.held == RAW_CODE_WIDE);
    end else begin
      case (cfg.fmt)
        FMT_RAW:  kind = K_EMIT;
        FMT_WIDE: kind = K_HOLD;
        default: begin
          kind    = K_OPEN;
          run_val = {5'd0, code_byte[7:5]};
          run_len = {4'd0, code_byte[4:0]} + LEN_W'(1);
          run_raw = (code_byte[7:5] == RAW_CODE_PACKED);
        end
      endcase
    end
    rem_dec = (cur.raw_rem != '0) ? cur.raw_rem - LEN_W'(1) : cur.raw_rem;
    end_col = {1'b0, cur.col} + SUM_W'(run_len);
    row_inc = {1'b0, cur.row} + (DIM_W+1)'(1);
    fits    = (end_col <= {1'b0, w});
    lr      = (end_col >= {1'b0, w});
    lf      = lr && (row_inc >= {1'b0, h});
  end

  // Next state.
  always_comb begin
    st_nxt = cur;
    case (kind)
      K_NONE: st_nxt = cur;
      K_HOLD: begin
        st_nxt.held  = code_byte;
        st_nxt.phase = PH_LEN;
      end
      K_BAD: begin
        st_nxt.err     = 1'b1;
        st_nxt.phase   = PH_CODE;
        st_nxt.raw_rem = '0;
      end
      K_EMIT: begin
        if (in_raw) begin
          st_nxt.raw_rem = rem_dec;
          st_nxt.phase   = (rem_dec == '0) ? PH_CODE : PH_RAW;
        end
        if (lr) begin
          st_nxt.col = '0;
          if (lf) st_nxt.done = 1'b1;
          else    st_nxt.row  = row_inc[DIM_W-1:0];
        end else begin
          st_nxt.col = end_col[DIM_W-1:0];
        end
      end
      K_OPEN: begin
        if (!fits) begin
          st_nxt.err     = 1'b1;
          st_nxt.phase   = PH_CODE;
          st_nxt.raw_rem = '0;
        end else if (run_raw) begin
          st_nxt.raw_rem = run_len;
          st_nxt.phase   = PH_RAW;
        end else begin
          st_nxt.phase = PH_CODE;
          if (lr) begin
            st_nxt.col = '0;
            if (lf) st_nxt.done = 1'b1;
            else    st_nxt.row  = row_inc[DIM_W-1:0];
          end else begin
            st_nxt.col = end_col[DIM_W-1:0];
          end
        end
      end
      default: st_nxt = cur;
    endcase
  end

  // Result.
  always_comb begin
    res               = '0;
    res.pixel_value   = run_val;
    res.run_length    = run_len;
    res.column        = cur.col[COL_W-1:0];
    res.row_index     = cur.row[COL_W-1:0];
    res.error_code    = ERR_NONE;
    case (kind)
      K_EMIT: begin
        res.valid         = 1'b1;
        res.last_of_row   = lr;
        res.last_of_frame = lf;
      end
      K_OPEN: begin
        if (!fits) begin
          res.valid      = 1'b1;
          res.error_code = ERR_RUN;
        end else if (!run_raw) begin
          res.valid         = 1'b1;
          res.last_of_row   = lr;
          res.last_of_frame = lf;
        end
      end
      K_BAD: begin
        res.valid       = 1'b1;
        res.pixel_value = '0;
        res.run_length  = '0;
        res.error_code  = ERR_WIDTH;
      end
      default: res.valid = 1'b0;
    endcase
  end

endmodule

>>> design/rsd_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_out_buf: result register with skid stage
// Holds up to two result beats so the input side keeps moving while the
// receiver stalls, until the skid entry is occupied.
// ----------------------------------------------------------------------------
module rsd_out_buf import rsd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output result_t out_data,
  output logic    out_valid,
  input  logic    out_stall
);

  result_t out_r, out_nxt;
  result_t skid_r, skid_nxt;
  logic    out_v_r, out_v_nxt;
  logic    skid_v_r, skid_v_nxt;
  logic    pop;

  assign pop       = out_v_r && !out_stall;
  assign full      = skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_comb begin
    out_nxt    = out_r;
    skid_nxt   = skid_r;
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    if (!out_v_r || pop) begin
      if (skid_v_r) begin
        out_nxt    = skid_r;
        out_v_nxt  = 1'b1;
        skid_v_nxt = 1'b0;
      end else begin
        out_nxt   = push_data;
        out_v_nxt = push;
      end
    end else if (push) begin
      skid_nxt   = push_data;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && skid_v_r))
    else $error("result pushed into a full buffer");

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held with empty output register");

  a_stall_holds_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && out_stall) |=> skid_v_r && $stable(out_r))
    else $error("buffered beat lost under stall");

endmodule

>>> design/sprite_rle_row_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_rle_row_decoder_unit: run-length row decoder for indexed sprites
// Turns the encoded pixel bytes of a sprite frame into pixel runs.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one encoded byte per beat; in_frame_start marks the first byte
//            of a frame and clears position, parse phase and error.
//   out_*  : at most one run per input beat (value, length, column, row,
//            row/frame end flags, error code). Code-only bytes give no beat.
//   cfg_*  : format, width and height; write only while the block is idle.
//            cfg_ready is always high, an index past the list is dropped.
// Output: a run is registered in the result buffer when its byte is accepted.
// Throughput: one byte per cycle while in_stall is low, set by the state update
//   loop (position, phase, held code and raw count) through rsd_step.
// Stall: a result register plus one skid entry sit on the output, so the
//   input keeps flowing while the receiver stalls until the skid entry is
//   occupied; then in_stall rises until the receiver takes a beat.
// Reset (rst_n low, synchronous): decoder state clears to the start of a
//   frame, registers go to format 0, width 1, height 1, the buffer empties.
// ----------------------------------------------------------------------------
module sprite_rle_row_decoder_unit import rsd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  // input bytes
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_code_byte,
  input  logic             in_frame_start,
  // pixel runs
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_pixel_value,
  output logic [LEN_W-1:0] out_run_length,
  output logic [COL_W-1:0] out_column,
  output logic [COL_W-1:0] out_row_index,
  output logic             out_last_of_row,
  output logic             out_last_of_frame,
  output logic [1:0]       out_error_code,
  // configuration writes
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [DIM_W-1:0] cfg_data
);

  cfg_t    cfg_r, cfg_nxt;
  state_t  st_r, st_nxt, step_nxt;
  result_t step_res;
  result_t buf_data;
  logic    buf_full;
  logic    in_acc;
  logic    cfg_acc;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_stall  = buf_full;
  assign in_acc    = in_valid && !in_stall;

  // Register writes; unknown index is dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_acc) begin
      case (reg_idx_t'(cfg_index))
        REG_FORMAT: cfg_nxt.fmt    = fmt_t'(cfg_data[1:0]);
        REG_WIDTH:  cfg_nxt.width  = cfg_data;
        REG_HEIGHT: cfg_nxt.height = cfg_data;
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  rsd_step u_step (
    .cfg         (cfg_r),
    .st          (st_r),
    .code_byte   (in_code_byte),
    .frame_start (in_frame_start),
    .st_nxt      (step_nxt),
    .res         (step_res)
  );

  // Advance the decoder state only on an accepted beat.
  assign st_nxt = in_acc ? step_nxt : st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{fmt: FMT_RAW, width: DIM_W'(1), height: DIM_W'(1)};
      st_r  <= '{col: '0, row: '0, phase: PH_CODE, held: '0, raw_rem: '0,
                 err: 1'b0, done: 1'b0};
    end else begin
      cfg_r <= cfg_nxt;
      st_r  <= st_nxt;
    end
  end

  rsd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc && step_res.valid),
    .push_data (step_res),
    .full      (buf_full),
    .out_data  (buf_data),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  assign out_pixel_value   = buf_data.pixel_value;
  assign out_run_length    = buf_data.run_length;
  assign out_column        = buf_data.column;
  assign out_row_index     = buf_data.row_index;
  assign out_last_of_row   = buf_data.last_of_row;
  assign out_last_of_frame = buf_data.last_of_frame;
  assign out_error_code    = buf_data.error_code;

  // An error run never closes a row or frame.
  a_err_no_last: assert property (@(posedge clk) disable iff (!rst_n)
    (step_res.valid && step_res.error_code != ERR_NONE) |->
      (!step_res.last_of_row && !step_res.last_of_frame))
    else $error("error result carries a last flag");

  // After an error beat, bytes are ignored until the next frame start.
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && step_res.valid && step_res.error_code != ERR_NONE) |=>
      ((in_acc && !in_frame_start) |-> !step_res.valid))
    else $error("result emitted after sticky error");

  // A finished frame stays quiet until the next frame start.
  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.done && !in_frame_start) |-> !step_res.valid)
    else $error("result emitted after frame completed");

endmodule

>>> tb/tb_sprite_rle_row_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sprite_rle_row_decoder_unit: self-checking bench of the sprite RLE decoder
// A short directed table covers reset values, every format, raw sequences,
// overflow and format-3 width errors, out-of-range dimensions and a format
// change mid-frame. Random frames follow, mostly well-formed run sequences
// with some noise and cut-off frames. Every result beat is checked field by
// field against a built-in decoder model, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_sprite_rle_row_decoder_unit import rsd_pkg::*; ;

  localparam int unsigned LIVE_TARGET = 1250;   // bytes that reach the decoder
  localparam int unsigned SETTLE      = 4;      // cycles past the output latency

  // Register index past the list; the block drops it.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // One expected pixel run, as it shows up on out_*.
  typedef struct packed {
    logic [7:0]       pix;
    logic [LEN_W-1:0] len;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] row;
    logic             last_row;
    logic             last_frame;
    err_t             err;
  } run_t;

  typedef enum logic { ROW_BYTE, ROW_CFG } step_kind_t;

  // One line of the directed table: a register write or an input byte,
  // optionally with its result typed in by hand.
  typedef struct packed {
    step_kind_t       kind;
    logic [1:0]       idx;
    logic [DIM_W-1:0] data;
    logic [7:0]       b;
    logic             fs;
    logic             pinned;
    run_t             want;
  } step_t;

  // --------------------------------------------------------------------------
  // DUT signals: every input starts at a known value
  // --------------------------------------------------------------------------
  logic             clk            = 1'b0;
  logic             rst_n          = 1'b0;
  logic             in_valid       = 1'b0;
  logic             in_stall;
  logic [7:0]       in_code_byte   = 8'd0;
  logic             in_frame_start = 1'b0;
  logic             out_valid;
  logic             out_stall      = 1'b0;
  logic [7:0]       out_pixel_value;
  logic [LEN_W-1:0] out_run_length;
  logic [COL_W-1:0] out_column;
  logic [COL_W-1:0] out_row_index;
  logic             out_last_of_row;
  logic             out_last_of_frame;
  logic [1:0]       out_error_code;
  logic             cfg_valid      = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index      = 2'd0;
  logic [DIM_W-1:0] cfg_data       = '0;

  sprite_rle_row_decoder_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_code_byte      (in_code_byte),
    .in_frame_start    (in_frame_start),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_value   (out_pixel_value),
    .out_run_length    (out_run_length),
    .out_column        (out_column),
    .out_row_index     (out_row_index),
    .out_last_of_row   (out_last_of_row),
    .out_last_of_frame (out_last_of_frame),
    .out_error_code    (out_error_code),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Decoder model: register copies and decode state, reset values
  // --------------------------------------------------------------------------
  fmt_t             fmt_reg    = FMT_RAW;
  logic [DIM_W-1:0] width_reg  = 15'd1;
  logic [DIM_W-1:0] height_reg = 15'd1;

  int unsigned cur_col      = 0;
  int unsigned cur_row      = 0;
  phase_t      ph           = PH_CODE;
  logic [7:0]  code_latch   = 8'd0;
  int unsigned raw_left     = 0;
  bit          halted_err   = 1'b0;
  bit          frame_closed = 1'b0;

  run_t  run_q[$];            // runs predicted but not yet seen on out_*
  step_t directed_steps[$];

  int unsigned fail_count   = 0;
  int unsigned live_bytes   = 0;
  int unsigned runs_checked = 0;
  int unsigned setups       = 0;
  bit          no_idle      = 1'b0;   // both sides run back to back while set
  bit          open_frame   = 1'b0;   // next random byte carries frame_start
  int unsigned frame_bytes  = 0;

  // Append at the tail of the expected-run and directed-table queues.
  function automatic void add_expect(input run_t r);
    run_q.insert(run_q.size(), r);
  endfunction

  function automatic void add_step(input step_t s);
    directed_steps.insert(directed_steps.size(), s);
  endfunction

  function automatic run_t make_run(input logic [7:0] pix, input int unsigned len,
                                    input int unsigned col, input int unsigned row,
                                    input bit lr, input bit lf, input err_t err);
    run_t r;
    r.pix        = pix;
    r.len        = LEN_W'(len);
    r.col        = COL_W'(col);
    r.row        = COL_W'(row);
    r.last_row   = lr;
    r.last_frame = lf;
    r.err        = err;
    return r;
  endfunction

  // Zero acts as one, anything past the limit acts as the limit.
  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // Emit a run that fits, then advance column, row and the frame end.
  function automatic bit issue_run(input logic [7:0] pix, input int unsigned len,
                                   input int unsigned w, input int unsigned h,
                                   output run_t r);
    bit lr;
    bit lf;
    lr = 1'b0;
    lf = 1'b0;
    if (cur_col + len >= w) begin
      lr = 1'b1;
      lf = (cur_row + 1 >= h);
    end
    r = make_run(pix, len, cur_col, cur_row, lr, lf, ERR_NONE);
    cur_col += len;
    if (lr) begin
      cur_col = 0;
      if (lf) frame_closed = 1'b1;
      else    cur_row++;
    end
    return 1'b1;
  endfunction

  // Check a new run against the room left in the row; a raw run only arms
  // the byte counter, a filled run goes out at once.
  function automatic bit start_run(input logic [7:0] pix, input int unsigned len,
                                   input bit raw, input int unsigned w,
                                   input int unsigned h, output run_t r);
    if (!(cur_col <= w && len <= w - cur_col)) begin
      r          = make_run(pix, len, cur_col, cur_row, 1'b0, 1'b0, ERR_RUN);
      halted_err = 1'b1;
      ph         = PH_CODE;
      raw_left   = 0;
      return 1'b1;
    end
    if (raw) begin
      raw_left = len;
      ph       = PH_RAW;
      r        = '0;
      return 1'b0;
    end
    ph = PH_CODE;
    return issue_run(pix, len, w, h, r);
  endfunction

  // Advance the model by one accepted byte. live is low for an ignored byte.
  function automatic void decode_byte(input logic [7:0] b, input logic fs,
                                      output bit live, output bit has, output run_t r);
    int unsigned w;
    int unsigned h;
    logic [2:0]  c;
    w    = clamp_dim(width_reg);
    h    = clamp_dim(height_reg);
    live = 1'b0;
    has  = 1'b0;
    r    = '0;
    if (fs) begin
      cur_col      = 0;
      cur_row      = 0;
      ph           = PH_CODE;
      code_latch   = 8'd0;
      raw_left     = 0;
      halted_err   = 1'b0;
      frame_closed = 1'b0;
    end
    if (halted_err || frame_closed) return;
    live = 1'b1;
    // Format 3 needs whole 32-pixel groups per row; any byte trips it.
    if (fmt_reg == FMT_PACK32 && (w & PACK_LEN_MASK) != 0) begin
      r          = make_run(8'd0, 0, cur_col, cur_row, 1'b0, 1'b0, ERR_WIDTH);
      has        = 1'b1;
      halted_err = 1'b1;
      ph         = PH_CODE;
      raw_left   = 0;
      return;
    end
    // Pending length or raw bytes finish under whatever format was set.
    if (ph == PH_RAW) begin
      if (raw_left > 0) raw_left--;
      if (raw_left == 0) ph = PH_CODE;
      has = issue_run(b, 1, w, h, r);
      return;
    end
    if (ph == PH_LEN) begin
      has = start_run(code_latch, int'(b) + 1, code_latch == RAW_CODE_WIDE, w, h, r);
      return;
    end
    case (fmt_reg)
      FMT_RAW:  has = issue_run(b, 1, w, h, r);
      FMT_WIDE: begin
        code_latch = b;
        ph         = PH_LEN;
      end
      default: begin
        c   = b[7:5];
        has = start_run({5'd0, c}, int'(b[4:0]) + 1, c == RAW_CODE_PACKED, w, h, r);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Directed table builders
  // --------------------------------------------------------------------------
  function automatic void cfg_row(input logic [1:0] idx, input logic [DIM_W-1:0] data);
    step_t s;
    s      = '0;
    s.kind = ROW_CFG;
    s.idx  = idx;
    s.data = data;
    add_step(s);
  endfunction

  function automatic void byte_row(input logic [7:0] b, input logic fs);
    step_t s;
    s      = '0;
    s.kind = ROW_BYTE;
    s.b    = b;
    s.fs   = fs;
    add_step(s);
  endfunction

  function automatic void pinned_row(input logic [7:0] b, input logic fs, input run_t want);
    step_t s;
    s        = '0;
    s.kind   = ROW_BYTE;
    s.b      = b;
    s.fs     = fs;
    s.pinned = 1'b1;
    s.want   = want;
    add_step(s);
  endfunction

  function automatic int unsigned draw_gap();
    return no_idle ? 0 : $urandom_range(0, 19);
  endfunction

  // Run length for a well-formed run, now and then one pixel too long.
  function automatic int unsigned pick_len(input int unsigned rem, input int unsigned top);
    int unsigned m;
    m = (rem < top) ? rem : top;
    case ($urandom_range(0, 11))
      0:       return (rem < top) ? rem + 1 : top;
      1, 2, 3: return m;
      default: return $urandom_range(1, m);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Present one byte after a random gap, hold it until the beat is taken,
  // then predict its result. A pinned result overrides the prediction.
  task automatic send_byte(input logic [7:0] b, input logic fs,
                           input bit pinned = 1'b0, input run_t want = '0);
    int unsigned gap;
    bit          taken;
    bit          live;
    bit          has;
    run_t        r;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_code_byte   <= b;
    in_frame_start <= fs;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !in_stall;
    end
    decode_byte(b, fs, live, has, r);
    if (pinned)   add_expect(want);
    else if (has) add_expect(r);
    if (live) live_bytes++;
  endtask

  task automatic push_byte(input logic [7:0] b);
    send_byte(b, open_frame);
    open_frame = 1'b0;
    frame_bytes++;
  endtask

  // Drop valid, drain every expected run, then let any code-only byte settle.
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (run_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DIM_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (reg_idx_t'(idx))
      REG_FORMAT: fmt_reg    = fmt_t'(data[1:0]);
      REG_WIDTH:  width_reg  = data;
      REG_HEIGHT: height_reg = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One random frame: new registers, then runs until the frame closes, an
  // error halts it or the byte budget cuts it short.
  task automatic run_frame();
    fmt_t             f;
    logic [DIM_W-1:0] wv;
    logic [DIM_W-1:0] hv;
    int unsigned      cap;
    int unsigned      w;
    int unsigned      rem;
    int unsigned      len;
    quiesce();
    no_idle = ($urandom_range(0, 3) == 0);
    f = fmt_t'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0:       wv = '0;
      1:       wv = DIM_W'(MAX_DIM);
      2:       wv = '1;
      3:       wv = DIM_W'($urandom_range(1, 32767));
      default: wv = DIM_W'($urandom_range(1, 48));
    endcase
    if (f == FMT_PACK32 && $urandom_range(0, 4) != 0) wv = DIM_W'(32 * $urandom_range(1, 3));
    case ($urandom_range(0, 9))
      0:       hv = '0;
      1:       hv = '1;
      2:       hv = DIM_W'(MAX_DIM);
      default: hv = DIM_W'($urandom_range(1, 3));
    endcase
    write_reg(REG_FORMAT, DIM_W'(f));
    write_reg(REG_WIDTH, wv);
    write_reg(REG_HEIGHT, hv);
    if ($urandom_range(0, 19) == 0) write_reg(REG_UNUSED, DIM_W'($urandom));
    setups++;

    cap         = $urandom_range(20, 160);
    open_frame  = 1'b1;
    frame_bytes = 0;
    while (frame_bytes < cap) begin
      w   = clamp_dim(width_reg);
      rem = (open_frame || cur_col >= w) ? w : w - cur_col;
      if ($urandom_range(0, 39) == 0 && !open_frame) begin
        // Switch format mid-frame; pending bytes keep their meaning.
        quiesce();
        f = fmt_t'($urandom_range(0, 3));
        write_reg(REG_FORMAT, DIM_W'(f));
      end
      if ($urandom_range(0, 11) == 0) begin
        push_byte(8'($urandom));
      end else begin
        case (f)
          FMT_RAW: push_byte(8'($urandom));
          FMT_WIDE: begin
            len = pick_len(rem, 256);
            if ($urandom_range(0, 3) == 0) begin
              push_byte(RAW_CODE_WIDE);
              push_byte(8'(len - 1));
              repeat (len) push_byte(8'($urandom));
            end else begin
              push_byte(8'($urandom_range(0, 254)));
              push_byte(8'(len - 1));
            end
          end
          default: begin
            len = pick_len(rem, 32);
            if ($urandom_range(0, 3) == 0) begin
              push_byte({RAW_CODE_PACKED, 5'(len - 1)});
              repeat (len) push_byte(8'($urandom));
            end else begin
              push_byte({3'($urandom_range(0, 6)), 5'(len - 1)});
            end
          end
        endcase
      end
      if (halted_err || frame_closed) begin
        // Trailing bytes must be dropped until the next frame start.
        if ($urandom_range(0, 1) == 0) repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
        break;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall for a random count per beat, then take the next beat
  // --------------------------------------------------------------------------
  initial begin
    int unsigned hold;
    forever begin
      hold = draw_gap();
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: compare each taken beat with the oldest expected run
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    run_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (run_q.size() == 0) begin
        $display("%0t: unexpected run beat pix=%0d len=%0d col=%0d row=%0d err=%0d",
                 $time, out_pixel_value, out_run_length, out_column, out_row_index,
                 out_error_code);
        fail_count++;
      end else begin
        exp_r = run_q.pop_front();
        check_field("pixel_value",   exp_r.pix,        out_pixel_value);
        check_field("run_length",    exp_r.len,        out_run_length);
        check_field("column",        exp_r.col,        out_column);
        check_field("row_index",     exp_r.row,        out_row_index);
        check_field("last_of_row",   exp_r.last_row,   out_last_of_row);
        check_field("last_of_frame", exp_r.last_frame, out_last_of_frame);
        check_field("error_code",    int'(exp_r.err),  out_error_code);
        runs_checked++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    // Reset values: format 0, one pixel wide, one row.
    pinned_row(8'h00, 1'b1, make_run(8'h00, 1, 0, 0, 1'b1, 1'b1, ERR_NONE));
    byte_row(8'hFF, 1'b0);                  // frame closed, dropped
    pinned_row(8'hFF, 1'b1, make_run(8'hFF, 1, 0, 0, 1'b1, 1'b1, ERR_NONE));
    // Two-byte runs in a 4x2 frame: filled run, raw pair, then an overflow.
    cfg_row(REG_FORMAT, DIM_W'(FMT_WIDE));
    cfg_row(REG_WIDTH, 15'd4);
    cfg_row(REG_HEIGHT, 15'd2);
    byte_row(8'h12, 1'b1);                  // code only
    byte_row(8'h01, 1'b0);
    byte_row(RAW_CODE_WIDE, 1'b0);
    byte_row(8'h01, 1'b0);                  // opens two raw bytes
    byte_row(8'hAB, 1'b0);
    byte_row(8'hCD, 1'b0);                  // closes row 0
    byte_row(8'h07, 1'b0);
    pinned_row(8'hFF, 1'b0, make_run(8'h07, 256, 0, 1, 1'b0, 1'b0, ERR_RUN));
    byte_row(8'h00, 1'b0);                  // halted, dropped
    // Packed runs, width past the limit, height zero, a dropped register.
    cfg_row(REG_UNUSED, '1);
    cfg_row(REG_FORMAT, DIM_W'(FMT_PACKED));
    cfg_row(REG_WIDTH, '1);
    cfg_row(REG_HEIGHT, '0);
    byte_row({RAW_CODE_PACKED, 5'd0}, 1'b1);
    byte_row(8'h5A, 1'b0);
    byte_row(8'h1F, 1'b0);                  // longest packed run
    byte_row(8'h00, 1'b0);
    // Format 3 with a width off the 32-pixel grid, then on it.
    cfg_row(REG_FORMAT, DIM_W'(FMT_PACK32));
    cfg_row(REG_WIDTH, 15'd33);
    pinned_row(8'h00, 1'b1, make_run(8'h00, 0, 0, 0, 1'b0, 1'b0, ERR_WIDTH));
    byte_row(8'h3C, 1'b0);
    cfg_row(REG_WIDTH, 15'd32);
    cfg_row(REG_HEIGHT, 15'd1);
    pinned_row(8'h1F, 1'b1, make_run(8'h00, 32, 0, 0, 1'b1, 1'b1, ERR_NONE));
    // Length byte pending across a switch to format 0.
    cfg_row(REG_FORMAT, DIM_W'(FMT_WIDE));
    cfg_row(REG_WIDTH, 15'd8);
    cfg_row(REG_HEIGHT, DIM_W'(MAX_DIM));
    byte_row(RAW_CODE_WIDE, 1'b1);
    cfg_row(REG_FORMAT, DIM_W'(FMT_RAW));
    byte_row(8'h02, 1'b0);                  // still read as the length
    byte_row(8'h11, 1'b0);
    byte_row(8'h22, 1'b0);
    byte_row(8'h33, 1'b0);
    byte_row(8'h44, 1'b0);                  // back to plain format 0

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == ROW_CFG) begin
        quiesce();
        write_reg(directed_steps[i].idx, directed_steps[i].data);
      end else begin
        send_byte(directed_steps[i].b, directed_steps[i].fs,
                  directed_steps[i].pinned, directed_steps[i].want);
      end
    end

    while (live_bytes < LIVE_TARGET) run_frame();

    // Drain, then give a late extra beat the chance to show up.
    @(negedge clk);
    in_valid <= 1'b0;
    while (run_q.size() != 0) @(posedge clk);
    repeat (SETTLE + 4) @(posedge clk);

    $display("Decoded %0d bytes into %0d checked runs over %0d random frame setups,",
             live_bytes, runs_checked, setups);
    $display("covering all four formats, raw sequences, row overflow and width errors.");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard limit well above the slowest legal run.
  initial begin
    #6000000;
    $display("%0t: run timed out, %0d runs still expected", $time, run_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> sprite_rle_row_decoder_unit.f
design/rsd_pkg.sv
design/rsd_step.sv
design/rsd_out_buf.sv
design/sprite_rle_row_decoder_unit.sv
tb/tb_sprite_rle_row_decoder_unit.sv
